// ===== rtl/segment_triangle_hit_test_core_defines.svh =====
// assertion macros shared by the checker
`ifndef SEGMENT_TRIANGLE_HIT_TEST_CORE_DEFINES_SVH
`define SEGMENT_TRIANGLE_HIT_TEST_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define STH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define STH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sth_pkg.sv =====
package sth_pkg;

    // coordinate and normal widths, the unit normal value and internal datapath widths
    localparam int unsigned CoordW = 32;
    localparam int unsigned NormW = 16;
    localparam int unsigned NormOne = 16384;
    localparam int unsigned MantBits = 30;
    localparam int unsigned TBits = 30;
    localparam int unsigned CrossW = 68;
    localparam int unsigned EdgeW = 33;

    // register indexes
    localparam logic [2:0] RegStartX = 3'd0;
    localparam logic [2:0] RegStartY = 3'd1;
    localparam logic [2:0] RegStartZ = 3'd2;
    localparam logic [2:0] RegEndX = 3'd3;
    localparam logic [2:0] RegEndY = 3'd4;
    localparam logic [2:0] RegEndZ = 3'd5;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [NormW-1:0] norm_t;
    typedef logic signed [CrossW-1:0] cross_t;
    typedef logic signed [EdgeW-1:0] edge_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        edge_t x;
        edge_t y;
        edge_t z;
    } evec_t;

    typedef struct packed {
        norm_t x;
        norm_t y;
        norm_t z;
    } nvec_t;

endpackage

// ===== rtl/sth_pipe.sv =====
// arithmetic pipeline for the segment versus triangle test
module sth_pipe
    import sth_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  vec_t   va,
    input  vec_t   vb,
    input  vec_t   vc,
    input  vec_t   p0,
    input  vec_t   p1,
    output logic   out_valid,
    output logic   out_hit,
    output vec_t   out_point,
    output nvec_t  out_normal
);

    localparam int unsigned NSq = 2*MantBits + 2;
    localparam int unsigned QW = 32;
    localparam int unsigned NDiv = 16;
    localparam int unsigned TDiv = TBits + 1;
    // stage layout: 0 edges, 1 cross products, 2 magnitude, 3 leading bit,
    // 4 shift, 5 squares, 6 sum, 7..38 square root, 39..55 normal divide,
    // then signed normal, dot, t divide, point, edge tests
    localparam int unsigned SqrtSteps = 31;

    // ---------------- stage 0: edges ----------------
    logic v0_reg;
    vec_t a0_reg, b0_reg, c0_reg, p0_0_reg, p1_0_reg;
    evec_t e0_0_reg, e1_0_reg;

    function automatic evec_t vsub(vec_t u, vec_t v);
        evec_t r;
        r.x = EdgeW'(u.x) - EdgeW'(v.x);
        r.y = EdgeW'(u.y) - EdgeW'(v.y);
        r.z = EdgeW'(u.z) - EdgeW'(v.z);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        a0_reg <= va;
        b0_reg <= vb;
        c0_reg <= vc;
        p0_0_reg <= p0;
        p1_0_reg <= p1;
        e0_0_reg <= vsub(vb, va);
        e1_0_reg <= vsub(vc, vb);
    end

    // ---------------- stage 1: products of the cross ----------------
    logic v1_reg;
    logic signed [2*EdgeW-1:0] pp_reg [6];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        pp_reg[0] <= e0_0_reg.y * e1_0_reg.z;
        pp_reg[1] <= e0_0_reg.z * e1_0_reg.y;
        pp_reg[2] <= e0_0_reg.z * e1_0_reg.x;
        pp_reg[3] <= e0_0_reg.x * e1_0_reg.z;
        pp_reg[4] <= e0_0_reg.x * e1_0_reg.y;
        pp_reg[5] <= e0_0_reg.y * e1_0_reg.x;
    end

    // geometry carried alongside the normal computation
    typedef struct packed {
        vec_t  a;
        vec_t  b;
        vec_t  c;
        vec_t  s;
        vec_t  e;
    } geo_t;

    localparam int unsigned GeoLen = 6 + SqrtSteps + NDiv + 3;
    geo_t geo_reg [GeoLen];
    geo_t geo_in;
    assign geo_in = '{a: a0_reg, b: b0_reg, c: c0_reg, s: p0_0_reg, e: p1_0_reg};

    always_ff @(posedge clk)
    begin
        geo_reg[0] <= geo_in;
        for (int i = 1; i < GeoLen; i++)
            geo_reg[i] <= geo_reg[i-1];
    end

    // ---------------- stage 2: cross components and magnitude ----------------
    logic v2_reg;
    logic [CrossW-1:0] m2_reg [3];
    logic [2:0] neg2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cross_t cv;
            cv = CrossW'(pp_reg[2*i]) - CrossW'(pp_reg[2*i+1]);
            neg2_reg[i] <= cv[CrossW-1];
            m2_reg[i] <= cv[CrossW-1] ? CrossW'(-cv) : CrossW'(cv);
        end
    end

    // ---------------- stage 3: leading bit of the largest magnitude ----------------
    logic v3_reg;
    logic [CrossW-1:0] m3_reg [3];
    logic [2:0] neg3_reg;
    logic [6:0] top3_reg;
    logic [CrossW-1:0] orall;
    always_comb
    begin
        orall = m2_reg[0] | m2_reg[1] | m2_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [6:0] t;
        t = '0;
        for (int i = 0; i < CrossW; i++)
            if (orall[i])
                t = 7'(i + 1);
        top3_reg <= t;
        m3_reg <= m2_reg;
        neg3_reg <= neg2_reg;
    end

    // ---------------- stage 4: normalise to mantissa ----------------
    logic v4_reg;
    logic [MantBits-1:0] a4_reg [3];
    logic [2:0] neg4_reg;
    logic zero4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (top3_reg > 7'(MantBits))
                a4_reg[i] <= MantBits'(m3_reg[i] >> (top3_reg - 7'(MantBits)));
            else
                a4_reg[i] <= MantBits'(m3_reg[i] << (7'(MantBits) - top3_reg));
        end
        neg4_reg <= neg3_reg;
        zero4_reg <= (top3_reg == '0);
    end

    // ---------------- stage 5: squares ----------------
    logic v5_reg;
    logic [2*MantBits-1:0] sq5_reg [3];
    logic [MantBits-1:0] a5_reg [3];
    logic [2:0] neg5_reg;
    logic zero5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq5_reg[i] <= a4_reg[i] * a4_reg[i];
        a5_reg <= a4_reg;
        neg5_reg <= neg4_reg;
        zero5_reg <= zero4_reg;
    end

    // ---------------- stage 6: sum of squares ----------------
    typedef struct packed {
        logic [MantBits-1:0] ax;
        logic [MantBits-1:0] ay;
        logic [MantBits-1:0] az;
        logic [2:0] neg;
        logic zero;
    } nrm_t;

    logic v6_reg;
    logic [NSq-1:0] sum6_reg;
    nrm_t n6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        sum6_reg <= NSq'(sq5_reg[0]) + NSq'(sq5_reg[1]) + NSq'(sq5_reg[2]);
        n6_reg <= '{ax: a5_reg[0], ay: a5_reg[1], az: a5_reg[2],
                    neg: neg5_reg, zero: zero5_reg};
    end

    // ---------------- square root, one result bit a stage ----------------
    localparam int unsigned RootW = NSq/2;
    logic sq_v_reg [SqrtSteps+1];
    logic [NSq-1:0] sq_x_reg [SqrtSteps+1];
    logic [NSq-1:0] sq_r_reg [SqrtSteps+1];
    nrm_t sq_n_reg [SqrtSteps+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SqrtSteps; i++)
                sq_v_reg[i] <= 1'b0;
        end
        else
        begin
            sq_v_reg[0] <= v6_reg;
            for (int i = 1; i <= SqrtSteps; i++)
                sq_v_reg[i] <= sq_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg[0] <= sum6_reg;
        sq_r_reg[0] <= '0;
        sq_n_reg[0] <= n6_reg;
        for (int i = 1; i <= SqrtSteps; i++)
        begin
            logic [NSq-1:0] bitv, x, r;
            bitv = NSq'(1) << (2*(SqrtSteps - i));
            x = sq_x_reg[i-1];
            r = sq_r_reg[i-1];
            if (x >= r + bitv)
            begin
                sq_x_reg[i] <= x - (r + bitv);
                sq_r_reg[i] <= (r >> 1) + bitv;
            end
            else
            begin
                sq_x_reg[i] <= x;
                sq_r_reg[i] <= r >> 1;
            end
            sq_n_reg[i] <= sq_n_reg[i-1];
        end
    end

    // ---------------- normal divide, one quotient bit a stage ----------------
    // numerator a*2^14 + L/2, quotient at most 2^14, 15 bits
    localparam int unsigned DivNW = MantBits + 15;
    logic [RootW-1:0] len;
    assign len = RootW'(sq_r_reg[SqrtSteps]);

    logic dv_v_reg [NDiv+1];
    logic [DivNW-1:0] dv_rem_reg [NDiv+1][3];
    logic [NormW-1:0] dv_q_reg [NDiv+1][3];
    logic [RootW-1:0] dv_len_reg [NDiv+1];
    logic [2:0] dv_neg_reg [NDiv+1];
    logic dv_zero_reg [NDiv+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NDiv; i++)
                dv_v_reg[i] <= 1'b0;
        end
        else
        begin
            dv_v_reg[0] <= sq_v_reg[SqrtSteps];
            for (int i = 1; i <= NDiv; i++)
                dv_v_reg[i] <= dv_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        nrm_t nn;
        nn = sq_n_reg[SqrtSteps];
        dv_rem_reg[0][0] <= DivNW'(nn.ax) * DivNW'(NormOne) + DivNW'(len >> 1);
        dv_rem_reg[0][1] <= DivNW'(nn.ay) * DivNW'(NormOne) + DivNW'(len >> 1);
        dv_rem_reg[0][2] <= DivNW'(nn.az) * DivNW'(NormOne) + DivNW'(len >> 1);
        for (int k = 0; k < 3; k++)
            dv_q_reg[0][k] <= '0;
        dv_len_reg[0] <= len;
        dv_neg_reg[0] <= nn.neg;
        dv_zero_reg[0] <= nn.zero;
        for (int i = 1; i <= NDiv; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [DivNW+NDiv-1:0] sub;
                sub = (DivNW+NDiv)'(dv_len_reg[i-1]) << (NDiv - i);
                if ((DivNW+NDiv)'(dv_rem_reg[i-1][k]) >= sub)
                begin
                    dv_rem_reg[i][k] <= DivNW'((DivNW+NDiv)'(dv_rem_reg[i-1][k]) - sub);
                    dv_q_reg[i][k] <= dv_q_reg[i-1][k] | (NormW'(1) << (NDiv - i));
                end
                else
                begin
                    dv_rem_reg[i][k] <= dv_rem_reg[i-1][k];
                    dv_q_reg[i][k] <= dv_q_reg[i-1][k];
                end
            end
            dv_len_reg[i] <= dv_len_reg[i-1];
            dv_neg_reg[i] <= dv_neg_reg[i-1];
            dv_zero_reg[i] <= dv_zero_reg[i-1];
        end
    end

    // ---------------- signed normal ----------------
    logic vn_reg;
    nvec_t n_reg;
    geo_t gn;
    assign gn = geo_reg[GeoLen - 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vn_reg <= 1'b0;
        else
            vn_reg <= dv_v_reg[NDiv];
    end

    always_ff @(posedge clk)
    begin
        norm_t q [3];
        for (int k = 0; k < 3; k++)
        begin
            q[k] = dv_zero_reg[NDiv] ? '0 : dv_q_reg[NDiv][k];
            q[k] = dv_neg_reg[NDiv][k] ? -q[k] : q[k];
        end
        n_reg <= '{x: q[0], y: q[1], z: q[2]};
    end

    // ---------------- dot products, per-axis products then sums ----------------
    localparam int unsigned DotW = 52;
    logic vd1_reg;
    logic signed [DotW-1:0] dp_reg [3];
    logic signed [DotW-1:0] np_reg [3];
    nvec_t nd1_reg;
    evec_t w_d1_reg;
    geo_t gd1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd1_reg <= 1'b0;
        else
            vd1_reg <= vn_reg;
    end

    always_ff @(posedge clk)
    begin
        evec_t wv, dv;
        wv = vsub(gn.e, gn.s);
        dv = vsub(gn.a, gn.s);
        dp_reg[0] <= DotW'(n_reg.x) * DotW'(wv.x);
        dp_reg[1] <= DotW'(n_reg.y) * DotW'(wv.y);
        dp_reg[2] <= DotW'(n_reg.z) * DotW'(wv.z);
        np_reg[0] <= DotW'(n_reg.x) * DotW'(dv.x);
        np_reg[1] <= DotW'(n_reg.y) * DotW'(dv.y);
        np_reg[2] <= DotW'(n_reg.z) * DotW'(dv.z);
        nd1_reg <= n_reg;
        w_d1_reg <= wv;
        gd1_reg <= gn;
    end

    logic vd2_reg;
    logic [DotW-1:0] den_reg, num_reg;
    logic miss_d2_reg;
    nvec_t nd2_reg;
    evec_t w_d2_reg;
    geo_t gd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd2_reg <= 1'b0;
        else
            vd2_reg <= vd1_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [DotW-1:0] d, u;
        d = dp_reg[0] + dp_reg[1] + dp_reg[2];
        u = np_reg[0] + np_reg[1] + np_reg[2];
        if (d < 0)
        begin
            d = -d;
            u = -u;
        end
        miss_d2_reg <= (d == 0) || (u < 0) || (u > d);
        den_reg <= d;
        num_reg <= u;
        nd2_reg <= nd1_reg;
        w_d2_reg <= w_d1_reg;
        gd2_reg <= gd1_reg;
    end

    // ---------------- t divide, one bit a stage ----------------
    logic td_v_reg [TDiv+1];
    logic [DotW-1:0] td_r_reg [TDiv+1];
    logic [DotW-1:0] td_d_reg [TDiv+1];
    logic [QW-1:0] td_q_reg [TDiv+1];
    logic td_m_reg [TDiv+1];
    nvec_t td_n_reg [TDiv+1];
    evec_t td_w_reg [TDiv+1];
    geo_t td_g_reg [TDiv+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= TDiv; i++)
                td_v_reg[i] <= 1'b0;
        end
        else
        begin
            td_v_reg[0] <= vd2_reg;
            for (int i = 1; i <= TDiv; i++)
                td_v_reg[i] <= td_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        td_r_reg[0] <= num_reg;
        td_d_reg[0] <= den_reg;
        td_q_reg[0] <= '0;
        td_m_reg[0] <= miss_d2_reg;
        td_n_reg[0] <= nd2_reg;
        td_w_reg[0] <= w_d2_reg;
        td_g_reg[0] <= gd2_reg;
        for (int i = 1; i <= TDiv; i++)
        begin
            logic [DotW-1:0] r;
            logic [QW-1:0] q;
            r = td_r_reg[i-1];
            q = td_q_reg[i-1];
            if (i > 1)
            begin
                r = r << 1;
                q = q << 1;
            end
            if (r >= td_d_reg[i-1])
            begin
                r = r - td_d_reg[i-1];
                q = q | QW'(1);
            end
            td_r_reg[i] <= r;
            td_q_reg[i] <= q;
            td_d_reg[i] <= td_d_reg[i-1];
            td_m_reg[i] <= td_m_reg[i-1];
            td_n_reg[i] <= td_n_reg[i-1];
            td_w_reg[i] <= td_w_reg[i-1];
            td_g_reg[i] <= td_g_reg[i-1];
        end
    end

    // ---------------- crossing point ----------------
    localparam int unsigned OffW = QW + EdgeW;
    logic vx1_reg;
    logic [OffW-1:0] off_reg [3];
    logic [2:0] wneg_reg;
    logic mx1_reg;
    nvec_t nx1_reg;
    geo_t gx1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vx1_reg <= 1'b0;
        else
            vx1_reg <= td_v_reg[TDiv];
    end

    always_ff @(posedge clk)
    begin
        evec_t wv;
        logic [EdgeW-1:0] mw [3];
        wv = td_w_reg[TDiv];
        mw[0] = wv.x[EdgeW-1] ? EdgeW'(-wv.x) : EdgeW'(wv.x);
        mw[1] = wv.y[EdgeW-1] ? EdgeW'(-wv.y) : EdgeW'(wv.y);
        mw[2] = wv.z[EdgeW-1] ? EdgeW'(-wv.z) : EdgeW'(wv.z);
        for (int k = 0; k < 3; k++)
            off_reg[k] <= OffW'(td_q_reg[TDiv]) * OffW'(mw[k]);
        wneg_reg <= {wv.z[EdgeW-1], wv.y[EdgeW-1], wv.x[EdgeW-1]};
        mx1_reg <= td_m_reg[TDiv];
        nx1_reg <= td_n_reg[TDiv];
        gx1_reg <= td_g_reg[TDiv];
    end

    logic vx2_reg;
    vec_t x_reg;
    logic mx2_reg;
    nvec_t nx2_reg;
    geo_t gx2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vx2_reg <= 1'b0;
        else
            vx2_reg <= vx1_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [OffW-1:0] o [3];
        coord_t s [3];
        coord_t xv [3];
        s[0] = gx1_reg.s.x;
        s[1] = gx1_reg.s.y;
        s[2] = gx1_reg.s.z;
        for (int k = 0; k < 3; k++)
        begin
            o[k] = (off_reg[k] + (OffW'(1) << (TBits - 1))) >> TBits;
            xv[k] = wneg_reg[k] ? s[k] - CoordW'(o[k]) : s[k] + CoordW'(o[k]);
        end
        x_reg <= '{x: xv[0], y: xv[1], z: xv[2]};
        mx2_reg <= mx1_reg;
        nx2_reg <= nx1_reg;
        gx2_reg <= gx1_reg;
    end

    // ---------------- edge tests: d x n ----------------
    localparam int unsigned DnW = 51;
    logic ve1_reg;
    logic signed [DnW-1:0] pa_reg [3][6];
    evec_t ee_reg [3];
    logic me1_reg;
    nvec_t ne1_reg;
    vec_t xe1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve1_reg <= 1'b0;
        else
            ve1_reg <= vx2_reg;
    end

    always_ff @(posedge clk)
    begin
        vec_t vk [3];
        evec_t d;
        vk[0] = gx2_reg.a;
        vk[1] = gx2_reg.b;
        vk[2] = gx2_reg.c;
        for (int k = 0; k < 3; k++)
        begin
            d = vsub(x_reg, vk[k]);
            pa_reg[k][0] <= DnW'(d.y) * DnW'(nx2_reg.z);
            pa_reg[k][1] <= DnW'(d.z) * DnW'(nx2_reg.y);
            pa_reg[k][2] <= DnW'(d.z) * DnW'(nx2_reg.x);
            pa_reg[k][3] <= DnW'(d.x) * DnW'(nx2_reg.z);
            pa_reg[k][4] <= DnW'(d.x) * DnW'(nx2_reg.y);
            pa_reg[k][5] <= DnW'(d.y) * DnW'(nx2_reg.x);
        end
        ee_reg[0] <= vsub(gx2_reg.b, gx2_reg.a);
        ee_reg[1] <= vsub(gx2_reg.c, gx2_reg.b);
        ee_reg[2] <= vsub(gx2_reg.a, gx2_reg.c);
        me1_reg <= mx2_reg;
        ne1_reg <= nx2_reg;
        xe1_reg <= x_reg;
    end

    logic ve2_reg;
    logic signed [DnW-1:0] dn_reg [3][3];
    evec_t ee2_reg [3];
    logic me2_reg;
    nvec_t ne2_reg;
    vec_t xe2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve2_reg <= 1'b0;
        else
            ve2_reg <= ve1_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                dn_reg[k][i] <= pa_reg[k][2*i] - pa_reg[k][2*i+1];
        ee2_reg <= ee_reg;
        me2_reg <= me1_reg;
        ne2_reg <= ne1_reg;
        xe2_reg <= xe1_reg;
    end

    // products of edge and d x n, split into two half products of d x n
    localparam int unsigned LoW = 25;
    localparam int unsigned HiW = DnW - LoW;
    localparam int unsigned PartW = EdgeW + HiW;
    logic ve3_reg;
    logic signed [PartW-1:0] eh_reg [3][3];
    logic signed [PartW-1:0] el_reg [3][3];
    logic me3_reg;
    nvec_t ne3_reg;
    vec_t xe3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve3_reg <= 1'b0;
        else
            ve3_reg <= ve2_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            edge_t ev [3];
            ev[0] = ee2_reg[k].x;
            ev[1] = ee2_reg[k].y;
            ev[2] = ee2_reg[k].z;
            for (int i = 0; i < 3; i++)
            begin
                eh_reg[k][i] <= PartW'(ev[i]) * PartW'($signed(dn_reg[k][i][DnW-1:LoW]));
                el_reg[k][i] <= PartW'(ev[i])
                                * PartW'($signed({1'b0, dn_reg[k][i][LoW-1:0]}));
            end
        end
        me3_reg <= me2_reg;
        ne3_reg <= ne2_reg;
        xe3_reg <= xe2_reg;
    end

    // recombine the half products, 84 bits each
    localparam int unsigned AccW = 86;
    logic ve4_reg;
    logic signed [AccW-1:0] ep_reg [3][3];
    logic me4_reg;
    nvec_t ne4_reg;
    vec_t xe4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve4_reg <= 1'b0;
        else
            ve4_reg <= ve3_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                ep_reg[k][i] <= (AccW'(eh_reg[k][i]) <<< LoW) + AccW'(el_reg[k][i]);
        me4_reg <= me3_reg;
        ne4_reg <= ne3_reg;
        xe4_reg <= xe3_reg;
    end

    // final sign test and result register
    logic vo_reg;
    logic hit_reg;
    vec_t po_reg;
    nvec_t no_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= ve4_reg;
    end

    always_ff @(posedge clk)
    begin
        logic inside_ok;
        logic signed [AccW-1:0] acc;
        inside_ok = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            acc = ep_reg[k][0] + ep_reg[k][1] + ep_reg[k][2];
            if (acc < 0)
                inside_ok = 1'b0;
        end
        hit_reg <= inside_ok && !me4_reg;
        po_reg <= (inside_ok && !me4_reg) ? xe4_reg : '0;
        no_reg <= (inside_ok && !me4_reg) ? ne4_reg : '0;
    end

    assign out_valid = vo_reg;
    assign out_hit = hit_reg;
    assign out_point = po_reg;
    assign out_normal = no_reg;

endmodule

// ===== rtl/segment_triangle_hit_test_core.sv =====
// throughput: one triangle per cycle, set by the fully pipelined square root
// and dividers that take one result bit per stage
// reset: asynchronous active low, clears valid bits and the six segment registers
// busy is tied low: an item may start in every cycle and done cannot be held off
module segment_triangle_hit_test_core
    import sth_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    output logic               hit,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z
);

    vec_t p0_reg, p1_reg;
    vec_t pnt;
    nvec_t nrm;
    logic vld;

    // segment registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg <= '0;
            p1_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegStartX: p0_reg.x <= cfg_data;
                RegStartY: p0_reg.y <= cfg_data;
                RegStartZ: p0_reg.z <= cfg_data;
                RegEndX:   p1_reg.x <= cfg_data;
                RegEndY:   p1_reg.y <= cfg_data;
                RegEndZ:   p1_reg.z <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline, the binary point does not affect any operation
    sth_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && (FRAC_BITS >= 0)),
        .va         ('{x: a_x, y: a_y, z: a_z}),
        .vb         ('{x: b_x, y: b_y, z: b_z}),
        .vc         ('{x: c_x, y: c_y, z: c_z}),
        .p0         (p0_reg),
        .p1         (p1_reg),
        .out_valid  (vld),
        .out_hit    (hit),
        .out_point  (pnt),
        .out_normal (nrm)
    );

    assign busy = 1'b0;
    assign done = vld;
    assign point_x = pnt.x;
    assign point_y = pnt.y;
    assign point_z = pnt.z;
    assign normal_x = nrm.x;
    assign normal_y = nrm.y;
    assign normal_z = nrm.z;

endmodule

// ===== rtl/sth_checker.sv =====
`include "segment_triangle_hit_test_core_defines.svh"

// port level checks on the result side and on busy
module sth_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               hit,
    input logic signed [31:0] point_x,
    input logic signed [15:0] normal_x,
    input logic signed [15:0] normal_y,
    input logic signed [15:0] normal_z
);

    // a miss shows zeros on point_x and on all normal components
    `STH_ASSERT_IMP(a_miss_zero, clk, rst_n, done && !hit,
        point_x == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0)
    // normal_x within unit range on a hit
    `STH_ASSERT_IMP(a_norm_range, clk, rst_n, done && hit,
        normal_x <= 16384 && normal_x >= -16384)
    // busy is checked low after every start
    `STH_ASSERT_NEXT(a_no_busy, clk, rst_n, start, !busy)

endmodule

bind segment_triangle_hit_test_core sth_checker u_sth_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .hit      (hit),
    .point_x  (point_x),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z)
);
